[src/hcbs_pkg.sv]
`default_nettype none
package hcbs_pkg;
    localparam int BAG_SLOTS = 8;
    localparam int NSLOT = (BAG_SLOTS < 8) ? BAG_SLOTS : 8;
    localparam int FQ_DEPTH = 2;
    localparam int OQ_DEPTH = 4;

    typedef enum logic [2:0] {
        F_ADD_VERTEX = 3'd0,
        F_ADD_EDGE   = 3'd1,
        F_FORGET     = 3'd2,
        F_JOIN       = 3'd3,
        F_FINAL      = 3'd4
    } t_func;

    localparam logic [1:0] C_ABSENT = 2'd0;
    localparam logic [1:0] C_DEG0   = 2'd1;
    localparam logic [1:0] C_DEG1   = 2'd2;
    localparam logic [1:0] C_DEG2   = 2'd3;
    localparam logic [3:0] NOPART   = 4'd8;

    typedef struct packed {
        logic [2:0]  func;
        logic [2:0]  slot_a;
        logic [2:0]  slot_b;
        logic [15:0] deg_a;
        logic [23:0] partner_a;
        logic        closed_a;
        logic [15:0] deg_b;
        logic [23:0] partner_b;
        logic        closed_b;
    } t_in_item;

    typedef struct packed {
        logic [15:0] deg_out;
        logic [23:0] partner_out;
        logic        closed_out;
        logic        is_final;
        logic        last;
    } t_out_item;

    typedef enum logic [2:0] {
        S_IDLE, S_SETUP, S_WALK1, S_WALK2, S_CHECK, S_EMIT
    } t_state;

    function automatic t_out_item emit_w(input logic [15:0] d, input logic [23:0] p,
                                         input logic c, input logic fin,
                                         input logic lst);
        t_out_item o;
        o = '0;
        for (int s = 0; s < NSLOT; s++) begin
            o.deg_out[2*s +: 2] = d[2*s +: 2];
            if (d[2*s +: 2] == C_DEG1) o.partner_out[3*s +: 3] = p[3*s +: 3];
        end
        o.closed_out = c;
        o.is_final = fin;
        o.last = lst;
        return o;
    endfunction
endpackage
`default_nettype wire

[src/hamiltonian_cycle_bag_state_step_unit.sv]
// Add vertex/edge, forget, final: the result is registered in the front unit, then moves
// into the output queue when it has room. Join: degree sum, then the path walker, which
// takes one step per cycle; a sum reject skips the walk and frees the walker.
// Throughput: 1 non-join request per cycle while the output has room; a non-join request
// after a join waits until that join has left the join unit.
// Reset: synchronous active-low i_rst_n empties all queues.
`default_nettype none
module hamiltonian_cycle_bag_state_step_unit (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_push,
    input  wire hcbs_pkg::t_in_item  i_item,
    output logic                     o_full,
    input  wire logic                i_pop,
    output logic                     o_empty,
    output hcbs_pkg::t_out_item      o_item
);
    logic jv, jpop, jbusy, rv, r2, rtake, jrv, jtake;
    hcbs_pkg::t_in_item ji;
    hcbs_pkg::t_out_item r0, r1, jres;
    hcbs_pkg::t_out_item r_oq [hcbs_pkg::OQ_DEPTH];
    logic [1:0] r_wp, r_rp;
    logic [2:0] r_cnt;
    logic [1:0] nin;
    logic popd;

    hcbs_front u_front (
        .i_clk, .i_rst_n, .i_push, .i_item, .o_full,
        .o_jvalid(jv), .o_jitem(ji), .i_jpop(jpop), .i_jbusy(jbusy),
        .o_rvalid(rv), .o_r0(r0), .o_r2(r2), .o_r1(r1), .i_rtake(rtake)
    );

    hcbs_join u_join (
        .i_clk, .i_rst_n, .i_valid(jv), .i_item(ji), .o_pop(jpop), .o_busy(jbusy),
        .o_rvalid(jrv), .o_res(jres), .i_rtake(jtake)
    );

    assign popd = i_pop && r_cnt != 3'd0;
    assign rtake = rv && (r_cnt <= 3'd2);
    assign jtake = jrv && !rtake && (r_cnt <= 3'd3);
    assign nin = rtake ? (r2 ? 2'd2 : 2'd1) : (jtake ? 2'd1 : 2'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0; r_rp <= '0; r_cnt <= '0;
        end else begin
            if (rtake) begin
                r_oq[r_wp] <= r0;
                if (r2) r_oq[r_wp + 2'd1] <= r1;
            end else if (jtake) begin
                r_oq[r_wp] <= jres;
            end
            r_wp <= r_wp + nin;
            if (popd) r_rp <= r_rp + 2'd1;
            r_cnt <= r_cnt + 3'(nin) - 3'(popd);
        end
    end

    assign o_empty = r_cnt == 3'd0;
    assign o_item = r_oq[r_rp];
endmodule
`default_nettype wire

[src/hcbs_front.sv]
`default_nettype none
// accepts requests, masks slots, handles everything except join
module hcbs_front (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    input  wire hcbs_pkg::t_in_item i_item,
    output logic                   o_full,
    // join requests are queued here for the join unit
    output logic                   o_jvalid,
    output hcbs_pkg::t_in_item     o_jitem,
    input  wire logic              i_jpop,
    input  wire logic              i_jbusy,
    // direct results
    output logic                   o_rvalid,
    output hcbs_pkg::t_out_item    o_r0,
    output logic                   o_r2,
    output hcbs_pkg::t_out_item    o_r1,
    input  wire logic              i_rtake
);
    hcbs_pkg::t_in_item r_q [hcbs_pkg::FQ_DEPTH];
    logic r_wp, r_rp;
    logic [1:0] r_cnt;
    logic r_rv, r_two;
    hcbs_pkg::t_out_item r_o0, r_o1;

    hcbs_pkg::t_in_item m;
    logic [15:0] dm;
    logic v_ok, v_two;
    hcbs_pkg::t_out_item v0, v1;
    logic acc, is_join, jpush, dpush, rfree;

    always_comb begin
        dm = '0;
        for (int s = 0; s < hcbs_pkg::NSLOT; s++) dm[2*s +: 2] = i_item.deg_a[2*s +: 2];
        m = i_item;
        m.deg_a = dm;
        for (int s = 0; s < 16; s++) if (s >= 2*hcbs_pkg::NSLOT) m.deg_b[s] = 1'b0;
    end

    always_comb begin
        logic [15:0] d;
        logic [23:0] p;
        logic c, ext, fin;
        logic [2:0] i, j, mi, mj;
        logic [1:0] ci, cj;
        logic [3:0] n0, n1;
        d = dm; p = i_item.partner_a; c = i_item.closed_a;
        i = i_item.slot_a; j = i_item.slot_b;
        v_ok = 1'b0; v_two = 1'b0; ext = 1'b0; fin = 1'b0;
        v0 = '0; v1 = '0;
        n0 = '0; n1 = '0;
        for (int s = 0; s < hcbs_pkg::NSLOT; s++) begin
            n0 = n0 + 4'(dm[2*s +: 2] == hcbs_pkg::C_DEG0);
            n1 = n1 + 4'(dm[2*s +: 2] == hcbs_pkg::C_DEG1);
        end
        ci = dm[2*i +: 2]; cj = dm[2*j +: 2];
        mi = p[3*i +: 3]; mj = p[3*j +: 3];
        case (i_item.func)
            hcbs_pkg::F_ADD_VERTEX: begin
                if (32'(i) < hcbs_pkg::NSLOT && ci == hcbs_pkg::C_ABSENT && !c) begin
                    d[2*i +: 2] = hcbs_pkg::C_DEG0;
                    v_ok = 1'b1;
                    v0 = hcbs_pkg::emit_w(d, p, c, 1'b0, 1'b1);
                end
            end
            hcbs_pkg::F_ADD_EDGE: begin
                v_ok = 1'b1;
                if (!c && 32'(i) < hcbs_pkg::NSLOT && 32'(j) < hcbs_pkg::NSLOT
                        && i != j) begin
                    if (ci == hcbs_pkg::C_DEG0 && cj == hcbs_pkg::C_DEG0) begin
                        d[2*i +: 2] = hcbs_pkg::C_DEG1; d[2*j +: 2] = hcbs_pkg::C_DEG1;
                        p[3*i +: 3] = j; p[3*j +: 3] = i; ext = 1'b1;
                    end else if (ci == hcbs_pkg::C_DEG0 && cj == hcbs_pkg::C_DEG1) begin
                        d[2*i +: 2] = hcbs_pkg::C_DEG1; d[2*j +: 2] = hcbs_pkg::C_DEG2;
                        if (32'(mj) < hcbs_pkg::NSLOT) p[3*mj +: 3] = i;
                        p[3*i +: 3] = mj; ext = 1'b1;
                    end else if (ci == hcbs_pkg::C_DEG1 && cj == hcbs_pkg::C_DEG0) begin
                        d[2*i +: 2] = hcbs_pkg::C_DEG2; d[2*j +: 2] = hcbs_pkg::C_DEG1;
                        if (32'(mi) < hcbs_pkg::NSLOT) p[3*mi +: 3] = j;
                        p[3*j +: 3] = mi; ext = 1'b1;
                    end else if (ci == hcbs_pkg::C_DEG1 && cj == hcbs_pkg::C_DEG1) begin
                        if (mi != j) begin
                            d[2*i +: 2] = hcbs_pkg::C_DEG2; d[2*j +: 2] = hcbs_pkg::C_DEG2;
                            if (32'(mi) < hcbs_pkg::NSLOT) p[3*mi +: 3] = mj;
                            if (32'(mj) < hcbs_pkg::NSLOT) p[3*mj +: 3] = mi;
                            ext = 1'b1;
                        end else if (n0 == 4'd0 && n1 == 4'd2) begin
                            d[2*i +: 2] = hcbs_pkg::C_DEG2; d[2*j +: 2] = hcbs_pkg::C_DEG2;
                            c = 1'b1; ext = 1'b1;
                        end
                    end
                end
                v_two = ext;
                v0 = hcbs_pkg::emit_w(dm, i_item.partner_a, i_item.closed_a, 1'b0, !ext);
                v1 = hcbs_pkg::emit_w(d, p, c, 1'b0, 1'b1);
            end
            hcbs_pkg::F_FORGET: begin
                if (32'(i) < hcbs_pkg::NSLOT && ci == hcbs_pkg::C_DEG2) begin
                    d[2*i +: 2] = hcbs_pkg::C_ABSENT;
                    v_ok = 1'b1;
                    v0 = hcbs_pkg::emit_w(d, p, c, 1'b0, 1'b1);
                end
            end
            hcbs_pkg::F_FINAL: begin
                fin = c && n0 == 4'd0 && n1 == 4'd0;
                v_ok = 1'b1;
                v0 = hcbs_pkg::emit_w(dm, p, c, fin, 1'b1);
            end
            default: v_ok = 1'b0;
        endcase
    end

    assign is_join = i_item.func == hcbs_pkg::F_JOIN;
    assign rfree = !r_rv || i_rtake;
    // non-join requests wait until every earlier join has left the back unit
    assign o_full = (r_cnt == 2'(hcbs_pkg::FQ_DEPTH)) || !rfree
                    || (!is_join && (r_cnt != 2'd0 || i_jbusy));
    assign acc = i_push && !o_full;
    assign jpush = acc && is_join;
    assign dpush = acc && !is_join && v_ok;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0; r_rp <= 1'b0; r_cnt <= '0; r_rv <= 1'b0; r_two <= 1'b0;
        end else begin
            if (jpush) begin
                r_q[r_wp] <= m;
                r_wp <= !r_wp;
            end
            if (i_jpop && r_cnt != 2'd0) r_rp <= !r_rp;
            r_cnt <= r_cnt + 2'(jpush) - 2'(i_jpop && r_cnt != 2'd0);
            if (dpush) begin
                r_rv <= 1'b1; r_two <= v_two; r_o0 <= v0; r_o1 <= v1;
            end else if (i_rtake) begin
                r_rv <= 1'b0;
            end
        end
    end

    assign o_jvalid = r_cnt != 2'd0;
    assign o_jitem = r_q[r_rp];
    assign o_rvalid = r_rv;
    assign o_r0 = r_o0;
    assign o_r1 = r_o1;
    assign o_r2 = r_two;
endmodule
`default_nettype wire

[src/hcbs_join.sv]
`default_nettype none
// join: degree sum, then walks one slot per cycle
module hcbs_join (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    input  wire hcbs_pkg::t_in_item i_item,
    output logic                    o_pop,
    output logic                    o_busy,
    output logic                    o_rvalid,
    output hcbs_pkg::t_out_item     o_res,
    input  wire logic               i_rtake
);
    hcbs_pkg::t_state r_st, n_st;
    logic [15:0] r_d;
    logic [23:0] r_p;
    logic [3:0] r_pa [8];
    logic [3:0] r_pb [8];
    logic [7:0] r_vis;
    logic [2:0] r_s, r_cur;
    logic r_side, r_rej;
    logic [3:0] r_k;
    logic [1:0] r_cyc;
    logic r_rv;
    hcbs_pkg::t_out_item r_res;

    logic [3:0] nxt;
    logic done;
    logic [15:0] d0;
    logic [3:0] pa0 [8];
    logic [3:0] pb0 [8];
    logic rej0;
    logic any_open;
    logic [23:0] p_link;

    always_comb begin
        rej0 = 1'b0;
        d0 = '0;
        for (int s = 0; s < 8; s++) begin
            logic [1:0] a, b;
            logic [2:0] sm;
            a = i_item.deg_a[2*s +: 2]; b = i_item.deg_b[2*s +: 2];
            sm = 3'(a != 2'd0 ? a - 2'd1 : 2'd0) + 3'(b != 2'd0 ? b - 2'd1 : 2'd0);
            if (a != 2'd0 || b != 2'd0) begin
                if (sm > 3'd2) rej0 = 1'b1;
                d0[2*s +: 2] = 2'(sm + 3'd1);
            end
            pa0[s] = hcbs_pkg::NOPART;
            pb0[s] = hcbs_pkg::NOPART;
            if (a == hcbs_pkg::C_DEG1 &&
                32'(i_item.partner_a[3*s +: 3]) < hcbs_pkg::NSLOT &&
                32'(i_item.partner_a[3*s +: 3]) != s)
                pa0[s] = {1'b0, i_item.partner_a[3*s +: 3]};
            if (b == hcbs_pkg::C_DEG1 &&
                32'(i_item.partner_b[3*s +: 3]) < hcbs_pkg::NSLOT &&
                32'(i_item.partner_b[3*s +: 3]) != s)
                pb0[s] = {1'b0, i_item.partner_b[3*s +: 3]};
        end
    end

    always_comb begin
        any_open = 1'b0;
        for (int s = 0; s < 8; s++)
            if (r_d[2*s +: 2] == hcbs_pkg::C_DEG0 || r_d[2*s +: 2] == hcbs_pkg::C_DEG1)
                any_open = 1'b1;
    end

    always_comb begin
        p_link = r_p;
        p_link[3*r_s +: 3] = r_cur;
        p_link[3*r_cur +: 3] = r_s;
    end

    assign nxt = r_side ? r_pb[r_cur] : r_pa[r_cur];
    assign done = (32'(nxt) >= hcbs_pkg::NSLOT) || r_vis[nxt[2:0]];

    always_comb begin
        n_st = r_st;
        case (r_st)
            hcbs_pkg::S_IDLE:  if (i_valid) n_st = hcbs_pkg::S_SETUP;
            hcbs_pkg::S_SETUP: n_st = r_rej ? hcbs_pkg::S_EMIT : hcbs_pkg::S_WALK1;
            hcbs_pkg::S_WALK1, hcbs_pkg::S_WALK2:
                if (r_k == 4'd0 && 32'(r_s) == hcbs_pkg::NSLOT - 1 &&
                    !((r_st == hcbs_pkg::S_WALK1 && r_d[2*r_s +: 2] == hcbs_pkg::C_DEG1
                       && !r_vis[r_s]) ||
                      (r_st == hcbs_pkg::S_WALK2 && !r_vis[r_s] &&
                       (r_pa[r_s] != hcbs_pkg::NOPART || r_pb[r_s] != hcbs_pkg::NOPART))))
                    n_st = (r_st == hcbs_pkg::S_WALK1) ? hcbs_pkg::S_WALK2 : hcbs_pkg::S_CHECK;
                else if (r_k != 4'd0 && done && 32'(r_s) == hcbs_pkg::NSLOT - 1)
                    n_st = (r_st == hcbs_pkg::S_WALK1) ? hcbs_pkg::S_WALK2 : hcbs_pkg::S_CHECK;
            hcbs_pkg::S_CHECK: n_st = hcbs_pkg::S_EMIT;
            hcbs_pkg::S_EMIT:  if (!r_rv || i_rtake) n_st = hcbs_pkg::S_IDLE;
            default: n_st = hcbs_pkg::S_IDLE;
        endcase
    end

    always_comb o_pop = r_st == hcbs_pkg::S_IDLE && i_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= hcbs_pkg::S_IDLE; r_rv <= 1'b0;
        end else begin
            r_st <= n_st;
            if (r_st == hcbs_pkg::S_EMIT && (!r_rv || i_rtake)) begin
                r_rv <= !r_rej;
            end else if (i_rtake) begin
                r_rv <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_st)
            hcbs_pkg::S_IDLE: if (i_valid) begin
                r_rej <= rej0;
                r_d <= d0; r_p <= '0; r_vis <= '0;
                r_cyc <= 2'(i_item.closed_a) + 2'(i_item.closed_b);
                r_pa <= pa0; r_pb <= pb0;
            end
            hcbs_pkg::S_SETUP: begin
                r_s <= '0; r_k <= '0;
            end
            hcbs_pkg::S_WALK1, hcbs_pkg::S_WALK2: begin
                if (r_k == 4'd0) begin
                    if ((r_st == hcbs_pkg::S_WALK1 && r_d[2*r_s +: 2] == hcbs_pkg::C_DEG1
                         && !r_vis[r_s]) ||
                        (r_st == hcbs_pkg::S_WALK2 && !r_vis[r_s] &&
                         (r_pa[r_s] != hcbs_pkg::NOPART || r_pb[r_s] != hcbs_pkg::NOPART))) begin
                        r_vis[r_s] <= 1'b1;
                        r_cur <= r_s;
                        r_side <= r_pa[r_s] == hcbs_pkg::NOPART;
                        r_k <= 4'd1;
                        if (r_st == hcbs_pkg::S_WALK2 && r_cyc != 2'd2) r_cyc <= r_cyc + 2'd1;
                    end else begin
                        r_s <= (32'(r_s) == hcbs_pkg::NSLOT - 1) ? 3'd0 : r_s + 3'd1;
                    end
                end else if (done) begin
                    if (r_st == hcbs_pkg::S_WALK1) r_p <= p_link;
                    r_k <= 4'd0;
                    r_s <= (32'(r_s) == hcbs_pkg::NSLOT - 1) ? 3'd0 : r_s + 3'd1;
                end else begin
                    r_vis[nxt[2:0]] <= 1'b1;
                    r_cur <= nxt[2:0];
                    r_side <= !r_side;
                    r_k <= r_k + 4'd1;
                end
            end
            hcbs_pkg::S_CHECK:
                r_rej <= r_rej || r_cyc == 2'd2 || (r_cyc == 2'd1 && any_open);
            hcbs_pkg::S_EMIT: if (!r_rv || i_rtake)
                r_res <= hcbs_pkg::emit_w(r_d, r_p, r_cyc == 2'd1, 1'b0, 1'b1);
            default: ;
        endcase
    end

    assign o_busy = r_st != hcbs_pkg::S_IDLE || r_rv;
    assign o_rvalid = r_rv;
    assign o_res = r_res;
endmodule
`default_nettype wire

[sim/hcbs_checker.sv]
`timescale 1ns / 100ps
module hcbs_checker (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_push,
    input  wire hcbs_pkg::t_in_item  i_item,
    input  wire logic                i_full,
    input  wire logic                i_pop,
    input  wire logic                i_empty,
    input  wire hcbs_pkg::t_out_item i_res,
    output int                       o_errors,
    output int                       o_pending
);
    import hcbs_pkg::*;

    typedef struct {
        logic [1:0] code [8];
        logic [2:0] part [8];
        logic       closed;
    } t_wit;

    t_out_item witness_q[$];

    function automatic void expect_res(t_out_item o);
        witness_q.insert(witness_q.size(), o);
    endfunction

    function automatic t_wit unpack_wit(logic [15:0] d, logic [23:0] p, logic c);
        t_wit w;
        for (int s = 0; s < 8; s++) begin
            w.code[s] = (s < NSLOT) ? d[2*s +: 2] : C_ABSENT;
            w.part[s] = p[3*s +: 3];
        end
        w.closed = c;
        return w;
    endfunction

    function automatic t_out_item pack_wit(t_wit w, logic fin, logic lst);
        t_out_item o;
        o = '0;
        for (int s = 0; s < NSLOT; s++) begin
            o.deg_out[2*s +: 2] = w.code[s];
            if (w.code[s] == C_DEG1) o.partner_out[3*s +: 3] = w.part[s];
        end
        o.closed_out = w.closed;
        o.is_final = fin;
        o.last = lst;
        return o;
    endfunction

    function automatic void relink(ref t_wit w, input int s, input int v);
        if (s < NSLOT) w.part[s] = v[2:0];
    endfunction

    // follow a path alternating between the two partner maps, marking visited slots
    function automatic int trace_path(int s, int pa[8], int pb[8], ref bit seen[8]);
        int cur, side, nxt;
        cur = s;
        side = (pa[s] != NOPART) ? 0 : 1;
        seen[s] = 1;
        for (int k = 0; k < NSLOT; k++) begin
            nxt = side ? pb[cur] : pa[cur];
            if (nxt >= NSLOT || seen[nxt]) break;
            seen[nxt] = 1;
            cur = nxt;
            side ^= 1;
        end
        return cur;
    endfunction

    function automatic void predict_join(t_wit a, t_wit b);
        t_wit r;
        int pa[8], pb[8], d, cyc, e;
        bit seen[8];
        for (int s = 0; s < 8; s++) begin
            r.code[s] = C_ABSENT; r.part[s] = 3'd0;
            pa[s] = int'(NOPART); pb[s] = int'(NOPART);
            seen[s] = 0;
        end
        r.closed = 1'b0;
        for (int s = 0; s < NSLOT; s++) begin
            if (a.code[s] == C_ABSENT && b.code[s] == C_ABSENT) continue;
            d = (a.code[s] != 0 ? a.code[s] - 1 : 0) + (b.code[s] != 0 ? b.code[s] - 1 : 0);
            if (d > 2) return;
            r.code[s] = 2'(d + 1);
            if (a.code[s] == C_DEG1 && a.part[s] < NSLOT && a.part[s] != s)
                pa[s] = int'(a.part[s]);
            if (b.code[s] == C_DEG1 && b.part[s] < NSLOT && b.part[s] != s)
                pb[s] = int'(b.part[s]);
        end
        for (int s = 0; s < NSLOT; s++)
            if (r.code[s] == C_DEG1 && !seen[s]) begin
                e = trace_path(s, pa, pb, seen);
                r.part[s] = 3'(e);
                r.part[e] = 3'(s);
            end
        cyc = int'(a.closed) + int'(b.closed);
        for (int s = 0; s < NSLOT; s++)
            if (!seen[s] && (pa[s] != NOPART || pb[s] != NOPART)) begin
                cyc++;
                void'(trace_path(s, pa, pb, seen));
            end
        if (cyc >= 2) return;
        if (cyc == 1) begin
            for (int s = 0; s < NSLOT; s++)
                if (r.code[s] == C_DEG0 || r.code[s] == C_DEG1) return;
            r.closed = 1'b1;
        end
        expect_res(pack_wit(r, 1'b0, 1'b1));
    endfunction

    function automatic void predict_edge(t_wit w, int i, int j);
        t_wit r;
        int n0, n1, m, mi, mj;
        bit ext;
        r = w; n0 = 0; n1 = 0; ext = 0;
        if (!w.closed && i < NSLOT && j < NSLOT && i != j) begin
            for (int s = 0; s < NSLOT; s++) begin
                n0 += (w.code[s] == C_DEG0);
                n1 += (w.code[s] == C_DEG1);
            end
            if (w.code[i] == C_DEG0 && w.code[j] == C_DEG0) begin
                r.code[i] = C_DEG1; r.code[j] = C_DEG1;
                r.part[i] = 3'(j); r.part[j] = 3'(i); ext = 1;
            end else if (w.code[i] == C_DEG0 && w.code[j] == C_DEG1) begin
                m = int'(w.part[j]);
                r.code[i] = C_DEG1; r.code[j] = C_DEG2;
                relink(r, m, i); r.part[i] = 3'(m); ext = 1;
            end else if (w.code[i] == C_DEG1 && w.code[j] == C_DEG0) begin
                m = int'(w.part[i]);
                r.code[i] = C_DEG2; r.code[j] = C_DEG1;
                relink(r, m, j); r.part[j] = 3'(m); ext = 1;
            end else if (w.code[i] == C_DEG1 && w.code[j] == C_DEG1) begin
                if (w.part[i] != j) begin
                    mi = int'(w.part[i]); mj = int'(w.part[j]);
                    r.code[i] = C_DEG2; r.code[j] = C_DEG2;
                    relink(r, mi, mj); relink(r, mj, mi); ext = 1;
                end else if (n0 == 0 && n1 == 2) begin
                    r.code[i] = C_DEG2; r.code[j] = C_DEG2;
                    r.closed = 1'b1; ext = 1;
                end
            end
        end
        expect_res(pack_wit(w, 1'b0, !ext));
        if (ext) expect_res(pack_wit(r, 1'b0, 1'b1));
    endfunction

    function automatic void predict_step(t_in_item it);
        t_wit a;
        bit fin;
        a = unpack_wit(it.deg_a, it.partner_a, it.closed_a);
        case (it.func)
            F_ADD_VERTEX: if (it.slot_a < NSLOT && a.code[it.slot_a] == C_ABSENT && !a.closed) begin
                a.code[it.slot_a] = C_DEG0;
                expect_res(pack_wit(a, 1'b0, 1'b1));
            end
            F_ADD_EDGE: predict_edge(a, int'(it.slot_a), int'(it.slot_b));
            F_FORGET: if (it.slot_a < NSLOT && a.code[it.slot_a] == C_DEG2) begin
                a.code[it.slot_a] = C_ABSENT;
                expect_res(pack_wit(a, 1'b0, 1'b1));
            end
            F_JOIN: predict_join(a, unpack_wit(it.deg_b, it.partner_b, it.closed_b));
            F_FINAL: begin
                fin = a.closed;
                for (int s = 0; s < NSLOT; s++)
                    if (a.code[s] == C_DEG0 || a.code[s] == C_DEG1) fin = 0;
                expect_res(pack_wit(a, fin, 1'b1));
            end
            default: ;
        endcase
    endfunction

    always @(posedge i_clk) begin
        t_out_item exp_res;
        int bad;
        bad = 0;
        if (!i_rst_n) begin
            o_errors <= o_errors;
        end else begin
            if (i_pop && !i_empty) begin
                if (witness_q.size() == 0) begin
                    $error("unexpected result deg_out=%h", i_res.deg_out);
                    bad++;
                end else begin
                    exp_res = witness_q.pop_front();
                    if (exp_res.deg_out !== i_res.deg_out) begin
                        $error("deg_out exp %h got %h", exp_res.deg_out, i_res.deg_out);
                        bad++;
                    end
                    if (exp_res.partner_out !== i_res.partner_out) begin
                        $error("partner_out exp %h got %h", exp_res.partner_out,
                               i_res.partner_out);
                        bad++;
                    end
                    if (exp_res.closed_out !== i_res.closed_out) begin
                        $error("closed_out exp %b got %b", exp_res.closed_out,
                               i_res.closed_out);
                        bad++;
                    end
                    if (exp_res.is_final !== i_res.is_final) begin
                        $error("is_final exp %b got %b", exp_res.is_final, i_res.is_final);
                        bad++;
                    end
                    if (exp_res.last !== i_res.last) begin
                        $error("last exp %b got %b", exp_res.last, i_res.last);
                        bad++;
                    end
                end
            end
            if (i_push && !i_full) predict_step(i_item);
            o_errors <= o_errors + bad;
        end
        o_pending <= witness_q.size();
    end

    initial begin
        o_errors = 0;
        o_pending = 0;
    end
endmodule

[sim/hamiltonian_cycle_bag_state_step_unit_tb.sv]
`timescale 1ns / 100ps
module hamiltonian_cycle_bag_state_step_unit_tb;
    import hcbs_pkg::*;

    logic      clk;
    logic      rst_n;
    logic      push;
    t_in_item  req;
    logic      full;
    logic      pop;
    logic      empty;
    t_out_item res;
    int        errors;
    int        pending;
    bit        hold_long;
    bit        hold_go;
    bit        calm;

    hamiltonian_cycle_bag_state_step_unit u_top (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_push  (push),
        .i_item  (req),
        .o_full  (full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_item  (res)
    );

    hcbs_checker u_checker (
        .i_clk     (clk),
        .i_rst_n   (rst_n),
        .i_push    (push),
        .i_item    (req),
        .i_full    (full),
        .i_pop     (pop),
        .i_empty   (empty),
        .i_res     (res),
        .o_errors  (errors),
        .o_pending (pending)
    );

    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // random well-formed witness over the live slots; partners of degree-1 ends pair up
    function automatic void rand_wit(output logic [15:0] d, output logic [23:0] p);
        int ends[$];
        int t;
        d = '0;
        p = 24'($urandom);
        for (int s = 0; s < NSLOT; s++) begin
            d[2*s +: 2] = 2'($urandom_range(0, 3));
            if (d[2*s +: 2] == C_DEG1) ends.insert(ends.size(), s);
        end
        ends.shuffle();
        if (ends.size() % 2) begin
            t = ends[ends.size() - 1];
            ends.delete(ends.size() - 1);
            d[2*t +: 2] = C_DEG2;
        end
        for (int k = 0; k + 1 < ends.size(); k += 2) begin
            p[3*ends[k] +: 3] = 3'(ends[k+1]);
            p[3*ends[k+1] +: 3] = 3'(ends[k]);
        end
    endfunction

    task automatic send(input t_in_item it);
        bit gap;
        gap = !calm && ($urandom_range(0, 5) == 0);
        if (gap) begin
            push <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clk);
        end
        push <= 1'b1;
        req <= it;
        @(posedge clk);
        while (full) @(posedge clk);
    endtask

    task automatic send_fields(input t_func f, input int sa, input int sb,
                               input logic [15:0] da, input logic [23:0] pa, input int ca,
                               input logic [15:0] db, input logic [23:0] pb,
                               input int cb);
        t_in_item it;
        it.func = f; it.slot_a = 3'(sa); it.slot_b = 3'(sb);
        it.deg_a = da; it.partner_a = pa; it.closed_a = 1'(ca);
        it.deg_b = db; it.partner_b = pb; it.closed_b = 1'(cb);
        send(it);
    endtask

    always @(posedge clk) begin
        if (!rst_n) begin
            pop <= 1'b0;
        end else if (hold_long) begin
            pop <= 1'b0;
        end else if (!calm && $urandom_range(0, 7) == 0) begin
            pop <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clk);
            pop <= 1'b1;
        end else begin
            pop <= 1'b1;
        end
    end

    initial begin
        t_in_item it;
        logic [15:0] d1, d2;
        logic [23:0] p1, p2;
        int wait_cnt;
        rst_n = 1'b0; push = 1'b0; req = '0; hold_go = 0; calm = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed
        send_fields(F_ADD_VERTEX, 0, 0, 16'h0000, 24'h0, 0, 16'h0, 24'h0, 0);
        send_fields(F_ADD_VERTEX, 7, 0, 16'hFFFF, 24'hFFFFFF, 0, 16'h0, 24'h0, 0);
        send_fields(F_ADD_VERTEX, 3, 0, 16'h0000, 24'h0, 1, 16'h0, 24'h0, 0);
        send_fields(F_ADD_EDGE, 0, 1, 16'h0005, 24'h0, 0, 16'h0, 24'h0, 0);
        send_fields(F_ADD_EDGE, 2, 0, 16'h002A, 24'h000008, 0, 16'h0, 24'h0, 0);
        send_fields(F_ADD_EDGE, 0, 1, 16'h003A, 24'h000010, 0, 16'h0, 24'h0, 0);
        send_fields(F_ADD_EDGE, 0, 2, 16'h00BA, 24'h0001C2, 0, 16'h0, 24'h0, 0);
        send_fields(F_ADD_EDGE, 0, 1, 16'h003A, 24'h000008, 0, 16'h0, 24'h0, 0);
        send_fields(F_ADD_EDGE, 0, 1, 16'h003A, 24'h000008, 1, 16'h0, 24'h0, 0);
        send_fields(F_ADD_EDGE, 4, 4, 16'h0300, 24'h0, 0, 16'h0, 24'h0, 0);
        send_fields(F_ADD_EDGE, 1, 0, 16'h000E, 24'h000007, 0, 16'h0, 24'h0, 0);
        send_fields(F_FORGET, 5, 0, 16'h0C00, 24'h0, 0, 16'h0, 24'h0, 0);
        send_fields(F_FORGET, 5, 0, 16'h0800, 24'h0, 0, 16'h0, 24'h0, 0);
        send_fields(F_JOIN, 0, 0, 16'h000A, 24'h000008, 0, 16'h000A, 24'h000008, 0);
        send_fields(F_JOIN, 0, 0, 16'h000F, 24'h0, 0, 16'h0009, 24'h0, 0);
        send_fields(F_JOIN, 0, 0, 16'h00FF, 24'h0, 1, 16'h0055, 24'h0, 0);
        send_fields(F_JOIN, 0, 0, 16'h0003, 24'h0, 1, 16'h0003, 24'h0, 1);
        send_fields(F_JOIN, 0, 0, 16'hAAAA, 24'hFFFFFF, 0, 16'h5555, 24'h000000, 0);
        send_fields(F_JOIN, 0, 0, 16'h0AA8, 24'h00E0C8, 0, 16'h0A0A, 24'h0, 0);
        send_fields(F_FINAL, 0, 0, 16'hFFFF, 24'h0, 1, 16'h0, 24'h0, 0);
        send_fields(F_FINAL, 0, 0, 16'h0007, 24'h0, 1, 16'h0, 24'h0, 0);
        send_fields(F_FINAL, 0, 0, 16'h0000, 24'h0, 0, 16'h0, 24'h0, 0);
        it = '0; it.func = 3'd5; send(it);
        it.func = 3'd7; it.deg_b = 16'hFFFF; it.partner_b = 24'hFFFFFF; it.closed_b = 1'b1;
        send(it);

        // random
        for (int n = 0; n < 400; n++) begin
            if (n == 150) hold_go = 1;
            if (n == 340) calm = 1;
            rand_wit(d1, p1);
            rand_wit(d2, p2);
            it.func = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(5, 7))
                                                   : 3'($urandom_range(0, 4));
            it.slot_a = 3'($urandom_range(0, 7));
            it.slot_b = 3'($urandom_range(0, 7));
            if ($urandom_range(0, 9) == 0) begin
                it.deg_a = 16'($urandom); it.partner_a = 24'($urandom);
                it.deg_b = 16'($urandom); it.partner_b = 24'($urandom);
            end else begin
                it.deg_a = d1; it.partner_a = p1; it.deg_b = d2; it.partner_b = p2;
            end
            it.closed_a = ($urandom_range(0, 5) == 0);
            it.closed_b = ($urandom_range(0, 5) == 0);
            send(it);
        end
        push <= 1'b0;
        wait_cnt = 0;
        while ((pending != 0 || !empty) && wait_cnt < 20000) begin
            @(posedge clk);
            wait_cnt++;
        end
        repeat (60) @(posedge clk);
        if (errors == 0 && pending == 0 && empty)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // long receiver hold-off, counted here
    initial begin
        int held;
        hold_long = 0;
        wait (hold_go);
        hold_long = 1;
        held = 0;
        while (held < 200) begin
            @(posedge clk);
            held++;
        end
        hold_long = 0;
    end

    initial begin
        #5ms;
        $display("Test completed with failures");
        $finish;
    end
endmodule
